[rtl/gnf_pkg.sv]
package gnf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_OCTAVES = 16;
    localparam int TABLE_SIZE  = 256;

    localparam logic signed [17:0] ONE_Q     = 18'sd65536;
    localparam logic signed [23:0] FADE_A_OFF = 24'sd983040;   // 15.0
    localparam logic signed [21:0] FADE_B_OFF = 22'sd655360;   // 10.0

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_FRACTAL = 2'd1;
    localparam logic [1:0] CMD_RIDGED  = 2'd2;

    typedef enum logic [4:0] {
        M_NONE, M_PX0, M_PX1, M_PY0, M_PY1,
        M_FA_X, M_FA_Y, M_FT2_X, M_FT2_Y, M_FT3_X, M_FT3_Y, M_FUV,
        M_L1, M_L2, M_L3, M_FR, M_RR, M_RW, M_RA, M_F0, M_F1, M_AD
    } mul_sel_t;

    typedef enum logic [4:0] {
        W_NONE, W_PX0, W_PX1, W_PY0, W_PY1, W_B, W_T2, W_T3, W_U, W_V,
        W_X1, W_X2, W_N, W_SQ, W_W, W_TOT, W_F0, W_F1, W_AMP
    } wb_sel_t;

    typedef enum logic [2:0] {
        RD_NONE, RD_HA, RD_HB, RD_AA, RD_AB, RD_BA, RD_BB, CAP_BB
    } mem_sel_t;

    typedef struct packed {
        logic     load;
        logic     ridged;
        logic     tbl_wr;
        logic     out_load;
        mul_sel_t mul;
        wb_sel_t  wb;
        mem_sel_t mem;
    } dp_cmd_t;

    // Gradient from the low three hash bits: four diagonal directions, each reached by two codes.
    function automatic logic signed [18:0] grad_f(input logic [2:0] h,
                                                  input logic signed [17:0] gx,
                                                  input logic signed [17:0] gy);
        logic signed [18:0] gu;
        logic signed [18:0] gv;
        gu = h[2] ? 19'(gy) : 19'(gx);
        gv = h[2] ? 19'(gx) : 19'(gy);
        if (h[0])
        begin
            gu = -gu;
        end
        if (h[1])
        begin
            gv = -gv;
        end
        return gu + gv;
    endfunction

endpackage

[rtl/gnf_if.sv]
interface gnf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [4:0]         octave_count;
    logic [15:0]        amp_decay;
    logic [15:0]        lacunarity;
    logic [7:0]         table_index;
    logic [7:0]         table_value;

    modport source (output valid, cmd, x_coord, y_coord, octave_count, amp_decay,
                    lacunarity, table_index, table_value, input ready);
    modport sink (input valid, cmd, x_coord, y_coord, octave_count, amp_decay,
                  lacunarity, table_index, table_value, output ready);
endinterface

interface gnf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink (input valid, noise_value, output ready);
endinterface

[rtl/gnf_datapath.sv]
module gnf_datapath import gnf_pkg::*; (
    input  logic               clk,
    input  dp_cmd_t            cmd,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic [15:0]        amp_decay,
    input  logic [15:0]        lacunarity,
    input  logic [7:0]         table_index,
    input  logic [7:0]         table_value,
    output logic signed [31:0] noise_value
);

    logic [7:0] perm_mem [TABLE_SIZE];
    logic [7:0] rd_addr;
    logic [7:0] rd_q;

    logic signed [31:0] x_reg, y_reg;
    logic [47:0]        freq_reg;
    logic [31:0]        amp_reg;
    logic [15:0]        decay_reg, lac_reg;
    logic [23:0]        px_reg, py_reg;
    logic [7:0]         ha_reg, hb_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic signed [21:0] fb_reg;
    logic signed [17:0] t2_reg, t3_reg, u_reg, v_reg;
    logic signed [19:0] x1_reg, x2_reg, n_reg;
    logic signed [18:0] sq_reg, w_reg, prev_reg;
    logic signed [39:0] total_reg;
    logic [39:0]        fq_lo_reg;
    logic signed [57:0] prod_reg;
    logic signed [31:0] noise_reg;

    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] sh16, sh15;
    logic signed [17:0] xf, yf, xm, ym;
    logic signed [23:0] fa_x, fa_y;
    logic signed [18:0] g00, g10, g01, g11;
    logic signed [19:0] r_val;
    logic [63:0]        freq_sum;

    assign xf = 18'($unsigned(px_reg[15:0]));
    assign yf = 18'($unsigned(py_reg[15:0]));
    assign xm = xf - ONE_Q;
    assign ym = yf - ONE_Q;

    // 6t - 15.0
    assign fa_x = $signed({6'b0, px_reg[15:0], 2'b0}) + $signed({7'b0, px_reg[15:0], 1'b0})
                  - FADE_A_OFF;
    assign fa_y = $signed({6'b0, py_reg[15:0], 2'b0}) + $signed({7'b0, py_reg[15:0], 1'b0})
                  - FADE_A_OFF;

    assign g00 = grad_f(aa_reg[2:0], xf, yf);
    assign g10 = grad_f(ba_reg[2:0], xm, yf);
    assign g01 = grad_f(ab_reg[2:0], xf, ym);
    assign g11 = grad_f(bb_reg[2:0], xm, ym);

    assign r_val = 20'(ONE_Q) - (n_reg[19] ? -n_reg : n_reg);

    assign sh16 = prod_reg >>> 16;
    assign sh15 = prod_reg >>> 15;
    assign freq_sum = {24'b0, fq_lo_reg} + {prod_reg[39:0], 24'b0};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul)
            M_NONE:  begin mul_a = '0; mul_b = '0; end
            M_PX0:   begin mul_a = 33'(x_reg); mul_b = 25'(freq_reg[23:0]); end
            M_PX1:   begin mul_a = 33'(x_reg); mul_b = 25'(freq_reg[39:24]); end
            M_PY0:   begin mul_a = 33'(y_reg); mul_b = 25'(freq_reg[23:0]); end
            M_PY1:   begin mul_a = 33'(y_reg); mul_b = 25'(freq_reg[39:24]); end
            M_FA_X:  begin mul_a = 33'(xf); mul_b = 25'(fa_x); end
            M_FA_Y:  begin mul_a = 33'(yf); mul_b = 25'(fa_y); end
            M_FT2_X: begin mul_a = 33'(xf); mul_b = 25'(xf); end
            M_FT2_Y: begin mul_a = 33'(yf); mul_b = 25'(yf); end
            M_FT3_X: begin mul_a = 33'(t2_reg); mul_b = 25'(xf); end
            M_FT3_Y: begin mul_a = 33'(t2_reg); mul_b = 25'(yf); end
            M_FUV:   begin mul_a = 33'(t3_reg); mul_b = 25'(fb_reg); end
            M_L1:    begin mul_a = 33'(u_reg); mul_b = 25'(20'(g10) - 20'(g00)); end
            M_L2:    begin mul_a = 33'(u_reg); mul_b = 25'(20'(g11) - 20'(g01)); end
            M_L3:    begin mul_a = 33'(v_reg); mul_b = 25'(21'(x2_reg) - 21'(x1_reg)); end
            M_FR:    begin mul_a = 33'(amp_reg); mul_b = 25'(n_reg); end
            M_RR:    begin mul_a = 33'(r_val); mul_b = 25'(r_val); end
            M_RW:    begin mul_a = 33'(sq_reg); mul_b = 25'(prev_reg); end
            M_RA:    begin mul_a = 33'(amp_reg); mul_b = 25'(w_reg); end
            M_F0:    begin mul_a = 33'(lac_reg); mul_b = 25'(freq_reg[23:0]); end
            M_F1:    begin mul_a = 33'(lac_reg); mul_b = 25'(freq_reg[47:24]); end
            M_AD:    begin mul_a = 33'(amp_reg); mul_b = 25'(decay_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        unique case (cmd.mem)
            RD_HA:   rd_addr = px_reg[23:16];
            RD_HB:   rd_addr = px_reg[23:16] + 8'd1;
            RD_AA:   rd_addr = ha_reg + py_reg[23:16];
            RD_AB:   rd_addr = ha_reg + py_reg[23:16] + 8'd1;
            RD_BA:   rd_addr = hb_reg + py_reg[23:16];
            RD_BB:   rd_addr = hb_reg + py_reg[23:16] + 8'd1;
            default: rd_addr = px_reg[23:16];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tbl_wr)
        begin
            perm_mem[table_index] <= table_value;
        end
        rd_q <= perm_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        unique case (cmd.mem)
            RD_HB:   ha_reg <= rd_q;
            RD_AA:   hb_reg <= rd_q;
            RD_AB:   aa_reg <= rd_q;
            RD_BA:   ab_reg <= rd_q;
            RD_BB:   ba_reg <= rd_q;
            CAP_BB:  bb_reg <= rd_q;
            default: ;
        endcase

        unique case (cmd.wb)
            W_PX0:   px_reg <= prod_reg[39:16];
            W_PX1:   px_reg <= px_reg + {prod_reg[15:0], 8'b0};
            W_PY0:   py_reg <= prod_reg[39:16];
            W_PY1:   py_reg <= py_reg + {prod_reg[15:0], 8'b0};
            W_B:     fb_reg <= sh16[21:0] + FADE_B_OFF;
            W_T2:    t2_reg <= sh16[17:0];
            W_T3:    t3_reg <= sh16[17:0];
            W_U:     u_reg <= sh16[17:0];
            W_V:     v_reg <= sh16[17:0];
            W_X1:    x1_reg <= 20'(g00) + sh16[19:0];
            W_X2:    x2_reg <= 20'(g01) + sh16[19:0];
            W_N:     n_reg <= x1_reg + sh16[19:0];
            W_SQ:    sq_reg <= sh16[18:0];
            W_W:
            begin
                w_reg    <= sh16[18:0];
                prev_reg <= sq_reg;
            end
            W_TOT:   total_reg <= total_reg + sh15[39:0];
            W_F0:    fq_lo_reg <= prod_reg[39:0];
            W_F1:    freq_reg <= freq_sum[59:12];
            W_AMP:   amp_reg <= sh15[31:0];
            default: ;
        endcase

        if (cmd.load)
        begin
            x_reg     <= x_coord;
            y_reg     <= y_coord;
            decay_reg <= amp_decay;
            lac_reg   <= lacunarity;
            freq_reg  <= 48'h1_0000;
            amp_reg   <= cmd.ridged ? 32'h4000 : 32'h8000;
            prev_reg  <= 19'(ONE_Q);
            total_reg <= '0;
        end

        if (cmd.out_load)
        begin
            if (total_reg > 40'sh007FFFFFFF)
            begin
                noise_reg <= 32'sh7FFFFFFF;
            end
            else if (total_reg < -40'sh0080000000)
            begin
                noise_reg <= -32'sh80000000;
            end
            else
            begin
                noise_reg <= total_reg[31:0];
            end
        end
    end

    assign noise_value = noise_reg;

endmodule

[rtl/gnf_ctrl.sv]
module gnf_ctrl import gnf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_cmd,
    input  logic [4:0] in_octaves,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINISH} state_t;

    localparam logic [4:0] STEP_NOISE_END = 5'd21;
    localparam logic [4:0] STEP_RIDGE     = 5'd22;
    localparam logic [4:0] STEP_RIDGE_END = 5'd26;
    localparam logic [4:0] STEP_FRACTAL   = 5'd27;
    localparam logic [4:0] STEP_TAIL      = 5'd28;
    localparam logic [4:0] STEP_LAST      = 5'd31;

    state_t     state_reg;
    logic [4:0] step_reg;
    logic [4:0] oct_left_reg;
    logic       ridged_reg;
    logic       out_valid_reg;

    logic       accept;
    logic       sample_go;
    logic       out_fire;
    logic [4:0] octs_clamped;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign sample_go = accept && (in_cmd == CMD_FRACTAL || in_cmd == CMD_RIDGED);
    assign out_fire  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign octs_clamped = (in_octaves > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : in_octaves;

    always_comb
    begin
        cmd          = '0;
        cmd.mul      = M_NONE;
        cmd.wb       = W_NONE;
        cmd.mem      = RD_NONE;
        cmd.load     = sample_go;
        cmd.ridged   = (in_cmd == CMD_RIDGED);
        cmd.tbl_wr   = accept && (in_cmd == CMD_WRITE);
        cmd.out_load = out_fire;
        if (state_reg == S_RUN)
        begin
            unique case (step_reg)
                5'd0:  cmd.mul = M_PX0;
                5'd1:  begin cmd.mul = M_PX1; cmd.wb = W_PX0; end
                5'd2:  begin cmd.mul = M_PY0; cmd.wb = W_PX1; end
                5'd3:  begin cmd.mul = M_PY1; cmd.wb = W_PY0; end
                5'd4:  cmd.wb = W_PY1;
                5'd5:  begin cmd.mul = M_FA_X; cmd.mem = RD_HA; end
                5'd6:  begin cmd.mul = M_FT2_X; cmd.wb = W_B; cmd.mem = RD_HB; end
                5'd7:  begin cmd.wb = W_T2; cmd.mem = RD_AA; end
                5'd8:  begin cmd.mul = M_FT3_X; cmd.mem = RD_AB; end
                5'd9:  begin cmd.wb = W_T3; cmd.mem = RD_BA; end
                5'd10: begin cmd.mul = M_FUV; cmd.mem = RD_BB; end
                5'd11: begin cmd.mul = M_FA_Y; cmd.wb = W_U; cmd.mem = CAP_BB; end
                5'd12: begin cmd.mul = M_FT2_Y; cmd.wb = W_B; end
                5'd13: cmd.wb = W_T2;
                5'd14: cmd.mul = M_FT3_Y;
                5'd15: cmd.wb = W_T3;
                5'd16: cmd.mul = M_FUV;
                5'd17: begin cmd.mul = M_L1; cmd.wb = W_V; end
                5'd18: begin cmd.mul = M_L2; cmd.wb = W_X1; end
                5'd19: cmd.wb = W_X2;
                5'd20: cmd.mul = M_L3;
                5'd21: cmd.wb = W_N;
                5'd22: cmd.mul = M_RR;
                5'd23: cmd.wb = W_SQ;
                5'd24: cmd.mul = M_RW;
                5'd25: cmd.wb = W_W;
                5'd26: cmd.mul = M_RA;
                5'd27: cmd.mul = M_FR;
                5'd28: begin cmd.mul = M_F0; cmd.wb = W_TOT; end
                5'd29: begin cmd.mul = M_F1; cmd.wb = W_F0; end
                5'd30: begin cmd.mul = M_AD; cmd.wb = W_F1; end
                5'd31: cmd.wb = W_AMP;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            oct_left_reg  <= '0;
            ridged_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample_go)
                    begin
                        ridged_reg   <= (in_cmd == CMD_RIDGED);
                        oct_left_reg <= octs_clamped;
                        step_reg     <= '0;
                        state_reg    <= (octs_clamped == '0) ? S_FINISH : S_RUN;
                    end
                end
                S_RUN:
                begin
                    priority if (step_reg == STEP_NOISE_END)
                    begin
                        step_reg <= ridged_reg ? STEP_RIDGE : STEP_FRACTAL;
                    end
                    else if (step_reg == STEP_RIDGE_END)
                    begin
                        step_reg <= STEP_TAIL;
                    end
                    else if (step_reg == STEP_LAST)
                    begin
                        step_reg     <= '0;
                        oct_left_reg <= oct_left_reg - 5'd1;
                        if (oct_left_reg == 5'd1)
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_FINISH:
                begin
                    if (out_fire)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_fractal_skips_ridge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && !ridged_reg)
            |-> !(step_reg >= STEP_RIDGE && step_reg <= STEP_RIDGE_END))
        else $error("fractal sample entered ridged steps");

    a_octaves_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (oct_left_reg != '0))
        else $error("running with no octaves left");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a pending transfer");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> out_valid_reg)
        else $error("finished sample not presented");

endmodule

[rtl/gradient_noise_fbm_ridge.sv]
// 2D gradient noise with fractal or ridged octave sums over a loaded 256-entry permutation
// table. A table write is one transfer; table entries are undefined until written, so
// load every entry a sample can reach first. Every product of a sample's octaves passes
// in sequence through the single shared 33x25 multiplier; the table is read once per
// cycle on its own port alongside. The result register frees the input side: a new
// sample is taken while the previous result still waits.
module gradient_noise_fbm_ridge import gnf_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    gnf_in_if.sink     sample,
    gnf_out_if.source  result
);

    dp_cmd_t cmd;

    gnf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample.valid),
        .in_ready   (sample.ready),
        .in_cmd     (sample.cmd),
        .in_octaves (sample.octave_count),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .cmd        (cmd)
    );

    gnf_datapath u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .x_coord     (sample.x_coord),
        .y_coord     (sample.y_coord),
        .amp_decay   (sample.amp_decay),
        .lacunarity  (sample.lacunarity),
        .table_index (sample.table_index),
        .table_value (sample.table_value),
        .noise_value (result.noise_value)
    );

endmodule
